FILE: rtl/ansi_sgr_text_cell_parser_core_defines.svh
// Assertion macros shared by the parser core.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ANSI_SGR_TEXT_CELL_PARSER_CORE_DEFINES_SVH
`define ANSI_SGR_TEXT_CELL_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ascp assertion failed");

// Next-cycle implication.
`define ASCP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ascp assertion failed");

`else

`define ASCP_ASSERT_IMP(label, ante, cons)
`define ASCP_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: rtl/ascp_pkg.sv
package ascp_pkg;

  localparam int TAB_STOP_DEFAULT = 8;
  localparam int MAX_RUN          = 8;
  localparam int CNT_W            = 4;   // holds 1..MAX_RUN
  localparam int GAP_W            = 5;   // holds 0..16 plus a tab run of 8
  localparam int ACC_W            = 10;
  localparam int ACC_WIDE_W       = 14;  // 1023*10 + 9 fits

  localparam logic [ACC_W-1:0] ACC_MAX      = 10'd1023;
  localparam logic [6:0]       ATTR_DEFAULT = 7'h07;  // fg 7, bg 0, no bold
  localparam logic [15:0]      COL_MAX      = 16'hFFFF;

  // byte codes
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SGR_END  = 8'h6D;

  // SGR codes
  localparam logic [ACC_W-1:0] SGR_RESET  = 10'd0;
  localparam logic [ACC_W-1:0] SGR_BOLD   = 10'd1;
  localparam logic [ACC_W-1:0] SGR_NORMAL = 10'd22;
  localparam logic [ACC_W-1:0] SGR_FG_LO  = 10'd30;
  localparam logic [ACC_W-1:0] SGR_FG_HI  = 10'd37;
  localparam logic [ACC_W-1:0] SGR_FG_DEF = 10'd39;
  localparam logic [ACC_W-1:0] SGR_BG_LO  = 10'd40;
  localparam logic [ACC_W-1:0] SGR_BG_HI  = 10'd47;
  localparam logic [ACC_W-1:0] SGR_BG_DEF = 10'd49;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } mode_t;

  // one run of results: a line end, a single cell, or a tab fill
  typedef struct packed {
    logic             kind;
    logic [7:0]       char_code;
    logic [6:0]       attribute;
    logic [15:0]      column;
    logic [CNT_W-1:0] cnt;
  } run_t;

  // packed style: fg [2:0], bg [5:3], bold [6]
  function automatic logic [6:0] attr_of(input logic [6:0] s);
    attr_of = {s[5:3], s[6], s[2:0]};
  endfunction

  function automatic logic [6:0] apply_code(input logic [ACC_W-1:0] p,
                                            input logic [6:0] s);
    logic [6:0] r;
    r = s;
    if (p == SGR_RESET) begin
      r = ATTR_DEFAULT;
    end else if (p == SGR_BOLD) begin
      r[6] = 1'b1;
    end else if (p == SGR_NORMAL) begin
      r[6] = 1'b0;
    end else if (p inside {[SGR_FG_LO:SGR_FG_HI]}) begin
      r[2:0] = 3'(p - SGR_FG_LO);
    end else if (p == SGR_FG_DEF) begin
      r[6]   = 1'b0;
      r[2:0] = 3'd7;
    end else if (p inside {[SGR_BG_LO:SGR_BG_HI]}) begin
      r[5:3] = 3'(p - SGR_BG_LO);
    end else if (p == SGR_BG_DEF) begin
      r[5:3] = 3'd0;
    end
    apply_code = r;
  endfunction

endpackage

FILE: rtl/ascp_in_if.sv
interface ascp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_text;

  modport source(output valid, byte_value, end_of_text, input ready);
  modport sink(input valid, byte_value, end_of_text, output ready);
endinterface

FILE: rtl/ascp_out_if.sv
interface ascp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_code;
  logic [6:0]  attribute;
  logic [15:0] column;
  logic        last_of_run;

  modport source(output valid, kind, char_code, attribute, column, last_of_run,
                 input ready);
  modport sink(input valid, kind, char_code, attribute, column, last_of_run,
               output ready);
endinterface

FILE: rtl/ascp_parser.sv
`include "ansi_sgr_text_cell_parser_core_defines.svh"

module ascp_parser #(
  parameter int TAB_STOP = ascp_pkg::TAB_STOP_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  ascp_in_if.sink          text,
  input  logic             free,
  output logic             load,
  output ascp_pkg::run_t   run_new
);

  localparam int PHASE_W = $clog2(TAB_STOP + 1);

  ascp_pkg::mode_t                    mode, mode_next;
  logic                               after_cr, after_cr_next;
  logic [ascp_pkg::ACC_W-1:0]         acc, acc_next;
  logic                               has_digits, has_digits_next;
  logic                               any_param, any_param_next;
  logic [6:0]                         staged, staged_next;
  logic [6:0]                         current, current_next;
  logic [15:0]                        col, col_next;
  logic [PHASE_W-1:0]                 phase, phase_next;  // col mod TAB_STOP

  logic                               accept;
  logic [7:0]                         b;
  logic                               text_path;
  logic [ascp_pkg::ACC_WIDE_W-1:0]    acc_wide;
  logic [6:0]                         sgr_end_attr;
  logic [ascp_pkg::GAP_W-1:0]         gap;
  logic [ascp_pkg::CNT_W-1:0]         tab_cnt, cell_cnt;
  logic [16:0]                        col_sum;
  logic [15:0]                        col_adv;
  logic [ascp_pkg::GAP_W-1:0]         inc, ph_sum;
  logic [PHASE_W-1:0]                 phase_adv;

  assign text.ready = free;
  assign accept     = text.valid && free;
  assign b          = text.byte_value;

  // digit accumulate: acc*10 + digit, saturating
  assign acc_wide = ascp_pkg::ACC_WIDE_W'({acc, 3'b000})
                  + ascp_pkg::ACC_WIDE_W'({acc, 1'b0})
                  + ascp_pkg::ACC_WIDE_W'(b[3:0]);

  // final 'm': pending digits apply, a bare "ESC [ m" counts as code 0
  always_comb begin
    if (has_digits) begin
      sgr_end_attr = ascp_pkg::apply_code(acc, staged);
    end else if (!any_param) begin
      sgr_end_attr = ascp_pkg::apply_code(ascp_pkg::SGR_RESET, staged);
    end else begin
      sgr_end_attr = staged;
    end
  end

  // tab width from the phase, clamped to one run
  assign gap     = ascp_pkg::GAP_W'(TAB_STOP) - ascp_pkg::GAP_W'(phase);
  assign tab_cnt = (gap > ascp_pkg::GAP_W'(ascp_pkg::MAX_RUN)) ?
                   ascp_pkg::CNT_W'(ascp_pkg::MAX_RUN) : gap[ascp_pkg::CNT_W-1:0];
  assign cell_cnt = (b == ascp_pkg::CH_TAB) ? tab_cnt : ascp_pkg::CNT_W'(1);

  // column after the cells, saturating; phase follows the real advance
  assign col_sum   = {1'b0, col} + 17'(cell_cnt);
  assign col_adv   = col_sum[16] ? ascp_pkg::COL_MAX : col_sum[15:0];
  assign inc       = ascp_pkg::GAP_W'(col_adv - col);
  assign ph_sum    = ascp_pkg::GAP_W'(phase) + inc;
  assign phase_adv = (ph_sum == ascp_pkg::GAP_W'(TAB_STOP)) ?
                     '0 : PHASE_W'(ph_sum);

  always_comb begin
    mode_next       = mode;
    after_cr_next   = after_cr;
    acc_next        = acc;
    has_digits_next = has_digits;
    any_param_next  = any_param;
    staged_next     = staged;
    current_next    = current;
    col_next        = col;
    phase_next      = phase;
    load            = 1'b0;
    text_path       = 1'b0;
    run_new.kind      = ascp_pkg::KIND_CELL;
    run_new.char_code = b;
    run_new.attribute = ascp_pkg::attr_of(current);
    run_new.column    = col;
    run_new.cnt       = ascp_pkg::CNT_W'(1);

    if (accept) begin
      if (text.end_of_text) begin
        load              = 1'b1;
        run_new.kind      = ascp_pkg::KIND_EOL;
        run_new.char_code = '0;
        run_new.attribute = '0;
        mode_next       = ascp_pkg::MODE_TEXT;
        after_cr_next   = 1'b0;
        acc_next        = '0;
        has_digits_next = 1'b0;
        any_param_next  = 1'b0;
        staged_next     = ascp_pkg::ATTR_DEFAULT;
        current_next    = ascp_pkg::ATTR_DEFAULT;
        col_next        = '0;
        phase_next      = '0;
      end else begin
        case (mode)
          ascp_pkg::MODE_CSI: begin
            if (b inside {[ascp_pkg::CH_DIGIT_0:ascp_pkg::CH_DIGIT_9]}) begin
              acc_next = (acc_wide > ascp_pkg::ACC_WIDE_W'(ascp_pkg::ACC_MAX)) ?
                         ascp_pkg::ACC_MAX : acc_wide[ascp_pkg::ACC_W-1:0];
              has_digits_next = 1'b1;
            end else if (b == ascp_pkg::CH_SEMI) begin
              staged_next = ascp_pkg::apply_code(
                              has_digits ? acc : ascp_pkg::SGR_RESET, staged);
              any_param_next  = 1'b1;
              acc_next        = '0;
              has_digits_next = 1'b0;
            end else if (b == ascp_pkg::CH_SGR_END) begin
              staged_next  = sgr_end_attr;
              current_next = sgr_end_attr;
              mode_next    = ascp_pkg::MODE_TEXT;
            end else begin
              mode_next = ascp_pkg::MODE_TEXT;
            end
          end
          ascp_pkg::MODE_ESC: begin
            if (b == ascp_pkg::CH_LBRACKET) begin
              mode_next       = ascp_pkg::MODE_CSI;
              staged_next     = current;
              acc_next        = '0;
              has_digits_next = 1'b0;
              any_param_next  = 1'b0;
            end else begin
              text_path = 1'b1;
            end
          end
          default: begin
            text_path = 1'b1;
          end
        endcase

        if (text_path) begin
          mode_next     = ascp_pkg::MODE_TEXT;
          after_cr_next = 1'b0;
          // LF directly after CR is swallowed
          if (!(after_cr && b == ascp_pkg::CH_LF)) begin
            case (b)
              ascp_pkg::CH_CR, ascp_pkg::CH_LF: begin
                load              = 1'b1;
                run_new.kind      = ascp_pkg::KIND_EOL;
                run_new.char_code = '0;
                run_new.attribute = '0;
                col_next          = '0;
                phase_next        = '0;
                after_cr_next     = (b == ascp_pkg::CH_CR);
              end
              ascp_pkg::CH_ESC: begin
                mode_next = ascp_pkg::MODE_ESC;
              end
              ascp_pkg::CH_TAB: begin
                load              = 1'b1;
                run_new.char_code = ascp_pkg::CH_SPACE;
                run_new.cnt       = tab_cnt;
                col_next          = col_adv;
                phase_next        = phase_adv;
              end
              default: begin
                load       = 1'b1;
                col_next   = col_adv;
                phase_next = phase_adv;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ascp_pkg::MODE_TEXT;
      after_cr   <= 1'b0;
      acc        <= '0;
      has_digits <= 1'b0;
      any_param  <= 1'b0;
      staged     <= ascp_pkg::ATTR_DEFAULT;
      current    <= ascp_pkg::ATTR_DEFAULT;
      col        <= '0;
      phase      <= '0;
    end else begin
      mode       <= mode_next;
      after_cr   <= after_cr_next;
      acc        <= acc_next;
      has_digits <= has_digits_next;
      any_param  <= any_param_next;
      staged     <= staged_next;
      current    <= current_next;
      col        <= col_next;
      phase      <= phase_next;
    end
  end

  // bytes inside a CSI sequence never produce output
  `ASCP_ASSERT_IMP(a_csi_silent,
                   accept && !text.end_of_text && mode == ascp_pkg::MODE_CSI,
                   !load)
  // a CR seen as text arms the LF swallow
  `ASCP_ASSERT_NXT(a_cr_arms,
                   accept && !text.end_of_text && mode != ascp_pkg::MODE_CSI &&
                   b == ascp_pkg::CH_CR,
                   after_cr)
  // a run is only loaded into a free slot
  `ASCP_ASSERT_IMP(a_load_free, load, free && text.valid)

endmodule

FILE: rtl/ascp_expander.sv
`include "ansi_sgr_text_cell_parser_core_defines.svh"

module ascp_expander (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ascp_pkg::run_t  run_new,
  output logic            free,
  ascp_out_if.source      cells
);

  ascp_pkg::run_t run;
  logic           run_valid;
  logic           out_valid;
  logic           out_kind;
  logic [7:0]     out_char;
  logic [6:0]     out_attr;
  logic [15:0]    out_col;
  logic           out_last;

  logic           out_take;
  logic           emit;
  logic           run_last;
  logic           run_done;

  assign out_take = !out_valid || cells.ready;
  assign emit     = run_valid && out_take;
  assign run_last = (run.cnt == ascp_pkg::CNT_W'(1));
  assign run_done = emit && run_last;
  assign free     = !run_valid || run_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        run_valid <= 1'b1;
      end else if (run_done) begin
        run_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // run payload: reload, or step one cell with a saturating column
  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_new;
    end else if (emit) begin
      run.cnt    <= run.cnt - ascp_pkg::CNT_W'(1);
      run.column <= (run.column == ascp_pkg::COL_MAX) ?
                    run.column : run.column + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= run.kind;
      out_char <= run.char_code;
      out_attr <= run.attribute;
      out_col  <= run.column;
      out_last <= run_last;
    end
  end

  assign cells.valid       = out_valid;
  assign cells.kind        = out_kind;
  assign cells.char_code   = out_char;
  assign cells.attribute   = out_attr;
  assign cells.column      = out_col;
  assign cells.last_of_run = out_last;

  // a live run always has words left
  `ASCP_ASSERT_IMP(a_run_nonempty, run_valid, run.cnt != '0)
  // a line end is a lone, blank word
  `ASCP_ASSERT_IMP(a_eol_word,
                   out_valid && out_kind == ascp_pkg::KIND_EOL,
                   out_last && out_char == 8'd0 && out_attr == 7'd0)
  // a tab run never exceeds its limit
  `ASCP_ASSERT_IMP(a_run_bound, run_valid,
                   run.cnt <= ascp_pkg::CNT_W'(ascp_pkg::MAX_RUN))

endmodule

FILE: rtl/ansi_sgr_text_cell_parser_core.sv
// ANSI SGR text cell parser.
// Channel text (sink): one byte of a text stream per word, with end_of_text
//   closing the document (the byte is then ignored).
// Channel cells (source): character cells (kind 0) carrying the byte, the
//   color attribute {bg, bold, fg} and the column, and line ends (kind 1)
//   carrying the length of the line just ended. last_of_run marks the final
//   word caused by one input byte.
// ESC [ params m sequences are parsed in place and produce no words.
// A byte that yields output reaches cells through the run register, then
//   the output register.
// Throughput: one byte per cycle while cells is ready, for bytes that yield
//   at most one word; a tab yields up to 8 space cells, one per cycle, and
//   stalls input until the run drains. The expander's run register sets this rate.
// Reset (rst, synchronous): parser state, attribute and column return to
//   their defaults (fg 7, bg 0, column 0); pending words are dropped.
// When cells is stalled the output word holds, the run register fills, and
//   text.ready drops until the run drains; bytes that give no output are
//   taken only while the run register is free.
module ansi_sgr_text_cell_parser_core #(
  parameter int TAB_STOP = ascp_pkg::TAB_STOP_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  ascp_in_if.sink     text,
  ascp_out_if.source  cells
);

  // handoff between parser and expander
  logic           free;
  logic           load;
  ascp_pkg::run_t run_new;

  // byte parser: escape state, SGR staging, column and tab phase
  ascp_parser #(
    .TAB_STOP (TAB_STOP)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .free    (free),
    .load    (load),
    .run_new (run_new)
  );

  // run expander: one result word per cycle into the output register while cells is ready
  ascp_expander u_expander (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .run_new (run_new),
    .free    (free),
    .cells   (cells)
  );

endmodule

FILE: sim/ascp_cell_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the parser core. Every accepted text word is run
// through a local copy of the parser. The cells it should cause are queued
// and then matched in order against the words leaving the block.
module ascp_cell_checker (
  input  logic clk,
  input  logic rst,
  ascp_in_if   text,
  ascp_out_if  cells,
  output int   fail_count,
  output int   pending
);
  import ascp_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [6:0]  attribute;
    logic [15:0] column;
    logic        last;
  } cell_word_t;

  typedef struct packed {
    logic       bold;
    logic [2:0] bg;
    logic [2:0] fg;
  } style_t;

  localparam style_t STYLE_DEFAULT = '{bold: 1'b0, bg: 3'd0, fg: 3'd7};

  cell_word_t expected_cells[$];

  mode_t            mode;
  logic             after_cr;
  logic [ACC_W-1:0] acc;
  logic             has_digits;
  logic             any_param;
  style_t           staged;
  style_t           current;
  logic [15:0]      col;

  task automatic clear_parser();
    mode       = MODE_TEXT;
    after_cr   = 1'b0;
    acc        = '0;
    has_digits = 1'b0;
    any_param  = 1'b0;
    staged     = STYLE_DEFAULT;
    current    = STYLE_DEFAULT;
    col        = '0;
  endtask

  // appends one predicted word at the tail of the queue
  function automatic void add_expected(input cell_word_t w);
    expected_cells.insert(expected_cells.size(), w);
  endfunction

  function automatic style_t sgr_update(input logic [ACC_W-1:0] code, input style_t s);
    style_t r;
    r = s;
    if (code == SGR_RESET) begin
      r = STYLE_DEFAULT;
    end else if (code == SGR_BOLD) begin
      r.bold = 1'b1;
    end else if (code == SGR_NORMAL) begin
      r.bold = 1'b0;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      r.fg = 3'(code - SGR_FG_LO);
    end else if (code == SGR_FG_DEF) begin
      // default foreground also drops bold
      r.bold = 1'b0;
      r.fg   = 3'd7;
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      r.bg = 3'(code - SGR_BG_LO);
    end else if (code == SGR_BG_DEF) begin
      r.bg = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [6:0] shown_attr(input style_t s);
    return 7'((int'(s.bg) << 4) + int'(s.fg) + (s.bold ? 8 : 0));
  endfunction

  // builds a cell at the current column and moves the column on
  function automatic cell_word_t next_cell(input logic [7:0] ch);
    cell_word_t w;
    w = '{kind: KIND_CELL, char_code: ch, attribute: shown_attr(current),
          column: col, last: 1'b0};
    if (col != COL_MAX) col = col + 16'd1;
    return w;
  endfunction

  function automatic cell_word_t line_end();
    cell_word_t w;
    w = '{kind: KIND_EOL, char_code: 8'd0, attribute: 7'd0, column: col, last: 1'b0};
    col = '0;
    return w;
  endfunction

  task automatic predict_cells(input logic [7:0] b, input logic eot);
    cell_word_t  run[MAX_RUN];
    int          n;
    int unsigned fill;
    int unsigned acc_next;
    n = 0;
    if (eot) begin
      run[0] = line_end();
      n = 1;
      clear_parser();
    end else if (mode == MODE_CSI) begin
      if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
        acc_next   = int'(acc) * 10 + int'(b - CH_DIGIT_0);
        acc        = (acc_next > ACC_MAX) ? ACC_MAX : ACC_W'(acc_next);
        has_digits = 1'b1;
      end else if (b == CH_SEMI) begin
        // empty field counts as a reset code
        staged     = sgr_update(has_digits ? acc : SGR_RESET, staged);
        any_param  = 1'b1;
        acc        = '0;
        has_digits = 1'b0;
      end else if (b == CH_SGR_END) begin
        if (has_digits) staged = sgr_update(acc, staged);
        else if (!any_param) staged = sgr_update(SGR_RESET, staged);
        current = staged;
        mode    = MODE_TEXT;
      end else begin
        // abort: staged style is simply never committed
        mode = MODE_TEXT;
      end
    end else if (mode == MODE_ESC && b == CH_LBRACKET) begin
      mode       = MODE_CSI;
      staged     = current;
      acc        = '0;
      has_digits = 1'b0;
      any_param  = 1'b0;
    end else begin
      // bare ESC falls through here and the byte is plain text
      mode = MODE_TEXT;
      if (after_cr && b == CH_LF) begin
        after_cr = 1'b0;
      end else begin
        after_cr = 1'b0;
        if (b == CH_CR) begin
          run[n] = line_end();
          n = n + 1;
          after_cr = 1'b1;
        end else if (b == CH_LF) begin
          run[n] = line_end();
          n = n + 1;
        end else if (b == CH_TAB) begin
          fill = TAB_STOP_DEFAULT - (int'(col) % TAB_STOP_DEFAULT);
          if (fill > MAX_RUN) fill = MAX_RUN;
          for (int i = 0; i < fill; i++) begin
            run[n] = next_cell(CH_SPACE);
            n = n + 1;
          end
        end else if (b == CH_ESC) begin
          mode = MODE_ESC;
        end else begin
          run[n] = next_cell(b);
          n = n + 1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      run[i].last = (i == n - 1);
      add_expected(run[i]);
    end
  endtask

  task automatic field_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  task automatic check_word();
    cell_word_t want;
    if (expected_cells.size() == 0) begin
      $display("%0t: unexpected word, expected none actual kind %0d char %0d col %0d",
               $time, cells.kind, cells.char_code, cells.column);
      fail_count++;
    end else begin
      want = expected_cells.pop_front();
      if (want.kind != cells.kind) field_mismatch("kind", want.kind, cells.kind);
      if (want.char_code != cells.char_code)
        field_mismatch("char_code", want.char_code, cells.char_code);
      if (want.attribute != cells.attribute)
        field_mismatch("attribute", want.attribute, cells.attribute);
      if (want.column != cells.column) field_mismatch("column", want.column, cells.column);
      if (want.last != cells.last_of_run)
        field_mismatch("last_of_run", want.last, cells.last_of_run);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_cells.delete();
      fail_count = 0;
    end else begin
      if (text.valid && text.ready) predict_cells(text.byte_value, text.end_of_text);
      if (cells.valid && cells.ready) check_word();
    end
    pending <= expected_cells.size();
  end

endmodule

FILE: sim/ansi_sgr_text_cell_parser_core_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the parser core. The checker beside the block
// does all prediction and comparison; this module only makes traffic.
module ansi_sgr_text_cell_parser_core_tb;
  import ascp_pkg::*;

  localparam int          DRAIN_CYCLES = 16;       // covers the run and output registers plus a tab run
  localparam int unsigned CYCLE_LIMIT  = 200_000;  // watchdog bound on the whole run
  localparam int          PHASE_WORDS  = 97;       // four phases plus directed, ~420 words

  logic clk = 1'b0;
  logic rst = 1'b1;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          phase_words;
  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;

  ascp_in_if  text_if();
  ascp_out_if cells_if();

  ansi_sgr_text_cell_parser_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .cells (cells_if)
  );

  ascp_cell_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .text       (text_if),
    .cells      (cells_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // receiver: random stalls at the current phase rate
  always @(posedge clk) begin
    cells_if.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One text word. Idle gaps are inserted before it at the sender rate.
  // valid is only raised or lowered once per edge, so back-to-back words
  // keep it high.
  task automatic send_word(input logic [7:0] b, input logic eot);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid       <= 1'b1;
    text_if.byte_value  <= b;
    text_if.end_of_text <= eot;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    phase_words++;
  endtask

  // decimal digits, most significant first
  task automatic send_number(input int unsigned v);
    int unsigned digits[10];
    int          nd;
    nd = 0;
    do begin
      digits[nd] = v % 10;
      nd = nd + 1;
      v = v / 10;
    end while (v != 0);
    for (int i = nd; i > 0; i--) send_word(8'(CH_DIGIT_0 + digits[i-1]), 1'b0);
  endtask

  // one of the known SGR codes, spread over every group
  function automatic int unsigned pick_sgr_code();
    int unsigned r;
    r = $urandom_range(20);
    if (r == 0) return SGR_RESET;
    if (r == 1) return SGR_BOLD;
    if (r == 2) return SGR_NORMAL;
    if (r <= 10) return SGR_FG_LO + (r - 3);
    if (r == 11) return SGR_FG_DEF;
    if (r <= 19) return SGR_BG_LO + (r - 12);
    return SGR_BG_DEF;
  endfunction

  // well-formed ESC [ p ; p ... m with random content
  task automatic send_sgr();
    int unsigned nparams;
    int unsigned r;
    send_word(CH_ESC, 1'b0);
    send_word(CH_LBRACKET, 1'b0);
    nparams = $urandom_range(3);
    for (int k = 0; k < nparams; k++) begin
      if (k > 0) send_word(CH_SEMI, 1'b0);
      r = $urandom_range(99);
      if (r < 70) send_number(pick_sgr_code());
      else if (r < 80) ;                                  // empty field
      else if (r < 90) send_number($urandom_range(1023));
      else send_number($urandom_range(99999, 1000));      // above 1023 this saturates the accumulator
    end
    send_word(CH_SGR_END, 1'b0);
  endtask

  task automatic send_chunk();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // raw bytes of any value: text plus noise
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) send_word(8'($urandom_range(255)), 1'b0);
    end else if (pick < 55) begin
      send_sgr();
    end else if (pick < 63) begin
      // CSI cut short by a byte that is no digit, ';' or 'm'
      send_word(CH_ESC, 1'b0);
      send_word(CH_LBRACKET, 1'b0);
      if ($urandom_range(1)) send_number(pick_sgr_code());
      do b = 8'($urandom_range(255));
      while ((b >= CH_DIGIT_0 && b <= CH_DIGIT_9) || b == CH_SEMI || b == CH_SGR_END);
      send_word(b, 1'b0);
    end else if (pick < 68) begin
      // bare ESC, next byte is text again unless it is '['
      send_word(CH_ESC, 1'b0);
      send_word(8'($urandom_range(255)), 1'b0);
    end else if (pick < 78) begin
      case ($urandom_range(3))
        0: send_word(CH_CR, 1'b0);
        1: send_word(CH_LF, 1'b0);
        2: begin
          send_word(CH_CR, 1'b0);
          send_word(CH_LF, 1'b0);
        end
        default: begin
          send_word(CH_CR, 1'b0);
          send_word(CH_CR, 1'b0);
        end
      endcase
    end else if (pick < 90) begin
      // a few cells then a tab, so the fill length varies
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) send_word(8'($urandom_range(126, 33)), 1'b0);
      send_word(CH_TAB, 1'b0);
    end else if (pick < 94) begin
      send_word(8'($urandom_range(255)), 1'b1);
    end else begin
      send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    phase_words   = 0;
    while (phase_words < PHASE_WORDS) send_chunk();
  endtask

  initial begin
    text_if.valid       = 1'b0;
    text_if.byte_value  = 8'd0;
    text_if.end_of_text = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, tab fill, CR LF pair, bold, fg and bg SGR codes, the
    // empty sequence, bare ESC, aborted CSI, end of text
    send_word("A", 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_ESC, 1'b0);
    send_word(CH_LBRACKET, 1'b0);
    send_number(SGR_BOLD);
    send_word(CH_SEMI, 1'b0);
    send_number(SGR_FG_LO + 1);
    send_word(CH_SEMI, 1'b0);
    send_number(SGR_BG_LO + 4);
    send_word(CH_SGR_END, 1'b0);
    send_word("x", 1'b0);
    send_word(CH_ESC, 1'b0);
    send_word(CH_LBRACKET, 1'b0);
    send_word(CH_SGR_END, 1'b0);
    send_word("y", 1'b0);
    send_word(CH_ESC, 1'b0);
    send_word("q", 1'b0);
    send_word(CH_ESC, 1'b0);
    send_word(CH_LBRACKET, 1'b0);
    send_number(SGR_FG_LO + 5);
    send_word("z", 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(8'hA5, 1'b1);

    // a cell, then a tab that fills only the rest of the stop
    send_word("Z", 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_LF, 1'b0);

    run_phase(0, 0);
    run_phase(46, 0);
    run_phase(0, 46);
    run_phase(27, 27);
    text_if.valid <= 1'b0;

    // pending is registered in the checker, so look one edge later
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
